>>> src/ldg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the greedy vertex partitioner.
package ldg_pkg;

	localparam int VTX_W     = 16;
	localparam int VTX_DEPTH = 1 << VTX_W;
	localparam int PART_W    = 4;
	localparam int PART_MAX  = 1 << PART_W;
	localparam int HOME_W    = PART_W + 1;
	localparam int CNT_W     = 17;
	localparam int LIMIT_W   = 17;
	localparam int PUSED_W   = 5;
	localparam int WEIGHT_W  = CNT_W + 1;
	localparam int PROD_W    = 2 * WEIGHT_W;
	localparam int HIT_SHIFT = 20;
	localparam int SCORE_W   = PROD_W + HIT_SHIFT;

	localparam logic [CNT_W-1:0]   CNT_MAX     = {CNT_W{1'b1}};
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(65536);
	localparam logic [PUSED_W-1:0] PUSED_RESET = PUSED_W'(4);
	localparam logic [PUSED_W-1:0] PUSED_MIN   = PUSED_W'(2);
	localparam logic [PUSED_W-1:0] PUSED_MAX   = PUSED_W'(PART_MAX);

	// Configuration register indexes
	localparam logic CFG_LIMIT = 1'b0;
	localparam logic CFG_PUSED = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HIT,
		ST_SCAN,
		ST_DRAIN,
		ST_PLACE
	} ldg_state_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic hit;
		logic scan;
		logic place;
	} ldg_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic is_last;
		logic fill;
		logic scan_end;
	} ldg_stat_t;

endpackage

>>> src/ldg_ctrl.sv
`timescale 1ns / 1ps
// Sequencer that steps the datapath through lookup, scoring and placement.
module ldg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ldg_pkg::ldg_stat_t stat,
	output ldg_pkg::ldg_cmd_t  cmd,
	output logic              busy
);
	import ldg_pkg::*;

	ldg_state_t state_q;
	ldg_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = ST_HIT;
			end
			ST_HIT: begin
				if (!stat.is_last) state_d = ST_IDLE;
				else if (stat.fill) state_d = ST_PLACE;
				else state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.scan_end) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_PLACE;
			end
			ST_PLACE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_CLEAR: cmd.clear = 1'b1;
			ST_IDLE: begin
				busy       = 1'b0;
				cmd.accept = start;
			end
			ST_HIT:   cmd.hit   = 1'b1;
			ST_SCAN:  cmd.scan  = 1'b1;
			ST_DRAIN: cmd       = '0;
			ST_PLACE: cmd.place = 1'b1;
			default:  cmd       = '0;
		endcase
	end

endmodule

>>> src/ldg_dp.sv
`timescale 1ns / 1ps
// Datapath: vertex home table, per-partition counters, scoring pipeline.
module ldg_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ldg_pkg::ldg_cmd_t            cmd,
	output ldg_pkg::ldg_stat_t           stat,
	input  logic [ldg_pkg::VTX_W-1:0]    vertex,
	input  logic [ldg_pkg::VTX_W-1:0]    neighbor,
	input  logic                         has_neighbor,
	input  logic                         last,
	input  logic [ldg_pkg::LIMIT_W-1:0]  limit,
	input  logic [ldg_pkg::PUSED_W-1:0]  parts,
	output logic                         done,
	output logic [ldg_pkg::VTX_W-1:0]    placed_vertex,
	output logic [ldg_pkg::PART_W-1:0]   partition
);
	import ldg_pkg::*;

	// Home table: 0 means unplaced, otherwise partition + 1
	logic [HOME_W-1:0] home_mem [VTX_DEPTH];
	logic [HOME_W-1:0] home_rd_q;
	logic [VTX_W-1:0]  clr_addr_q;

	logic [VTX_W-1:0]  vertex_q;
	logic              has_nbr_q;
	logic              last_q;

	logic [CNT_W-1:0]  size_q [PART_MAX];
	logic [CNT_W-1:0]  hits_q [PART_MAX];
	logic [CNT_W-1:0]  placed_total_q;

	logic [PART_W-1:0] scan_q;
	logic [PART_W-1:0] best_q;
	logic signed [SCORE_W-1:0] best_score_q;

	logic                       valid_s1;
	logic [PART_W-1:0]          idx_s1;
	logic signed [PROD_W-1:0]   prod_s1;
	logic signed [WEIGHT_W-1:0] weight_s1;

	logic signed [WEIGHT_W-1:0] hits_sx;
	logic signed [WEIGHT_W-1:0] weight;
	logic signed [SCORE_W-1:0]  score;
	logic [PART_W-1:0]          hit_part;
	logic [HOME_W-1:0]          home_wr;

	assign hit_part = PART_W'(home_rd_q - HOME_W'(1));
	assign home_wr  = HOME_W'({1'b0, best_q}) + HOME_W'(1);

	assign stat.clr_done = (clr_addr_q == {VTX_W{1'b1}});
	assign stat.is_last  = last_q;
	assign stat.fill     = (placed_total_q < CNT_W'(parts));
	assign stat.scan_end = (PUSED_W'(scan_q) == parts - PUSED_W'(1));

	// Table write and registered read
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			home_mem[clr_addr_q] <= '0;
		end else if (cmd.place) begin
			home_mem[vertex_q] <= home_wr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			home_rd_q <= home_mem[neighbor];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear) begin
			clr_addr_q <= clr_addr_q + VTX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			vertex_q  <= vertex;
			has_nbr_q <= has_neighbor;
			last_q    <= last;
		end
	end

	// Counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PART_MAX; i++) begin
				size_q[i] <= '0;
				hits_q[i] <= '0;
			end
			placed_total_q <= '0;
		end else if (cmd.place) begin
			for (int i = 0; i < PART_MAX; i++) begin
				hits_q[i] <= '0;
			end
			if (size_q[best_q] != CNT_MAX) size_q[best_q] <= size_q[best_q] + CNT_W'(1);
			if (placed_total_q != CNT_MAX) placed_total_q <= placed_total_q + CNT_W'(1);
		end else if (cmd.hit && has_nbr_q && (home_rd_q != '0)) begin
			if (hits_q[hit_part] != CNT_MAX) begin
				hits_q[hit_part] <= hits_q[hit_part] + CNT_W'(1);
			end
		end
	end

	// Stage 1: hits * (limit - size) for one partition
	assign hits_sx = $signed({1'b0, hits_q[scan_q]});
	assign weight  = $signed({1'b0, limit}) - $signed({1'b0, size_q[scan_q]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			scan_q   <= '0;
		end else begin
			valid_s1 <= cmd.scan;
			if (cmd.hit) scan_q <= '0;
			else if (cmd.scan) scan_q <= scan_q + PART_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			idx_s1    <= scan_q;
			prod_s1   <= hits_sx * weight;
			weight_s1 <= weight;
		end
	end

	// Stage 2: score = prod * 2^20 + weight, keep the first maximum
	assign score = (SCORE_W'(prod_s1) <<< HIT_SHIFT) + SCORE_W'(weight_s1);

	always_ff @(posedge clk) begin
		if (cmd.hit && stat.fill) begin
			best_q <= PART_W'(placed_total_q);
		end else if (valid_s1 && ((idx_s1 == '0) || (score > best_score_q))) begin
			best_q       <= idx_s1;
			best_score_q <= score;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.place;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.place) begin
			placed_vertex <= vertex_q;
			partition     <= best_q;
		end
	end

endmodule

>>> src/ldg_vertex_partitioner.sv
`timescale 1ns / 1ps
// Top level of the linear deterministic greedy vertex partitioner.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+----------------------------------------
//  request   | start, busy           | vertex, neighbor, has_neighbor, last
//  result    | done (one-cycle pulse)| placed_vertex, partition
//  config    | cfg_valid, cfg_ready  | cfg_index, cfg_data
//
// A request without last reads the table when accepted, then holds busy
// for the hit count. A last request goes from the hit count straight to
// placement while the first partitions are being filled, otherwise via scan
// and drain: one shared multiplier walks the active partitions one per cycle.
// After reset the home table is swept clear with busy high.
// done pulses for exactly one cycle; the receiver cannot stall it.
module ldg_vertex_partitioner (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [ldg_pkg::VTX_W-1:0]      vertex,
	input  logic [ldg_pkg::VTX_W-1:0]      neighbor,
	input  logic                           has_neighbor,
	input  logic                           last,
	output logic                           done,
	output logic [ldg_pkg::VTX_W-1:0]      placed_vertex,
	output logic [ldg_pkg::PART_W-1:0]     partition,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_index,
	input  logic [ldg_pkg::LIMIT_W-1:0]    cfg_data
);
	import ldg_pkg::*;

	ldg_cmd_t  cmd;
	ldg_stat_t stat;

	logic [LIMIT_W-1:0] limit_q;
	logic [PUSED_W-1:0] pused_q;
	logic [PUSED_W-1:0] parts;

	// Config writes are always taken; software is to write only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			pused_q <= PUSED_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LIMIT: limit_q <= cfg_data;
				CFG_PUSED: pused_q <= cfg_data[PUSED_W-1:0];
				default:   limit_q <= limit_q;
			endcase
		end
	end

	// Clamp the partition count into the supported range
	always_comb begin
		if (pused_q < PUSED_MIN) parts = PUSED_MIN;
		else if (pused_q > PUSED_MAX) parts = PUSED_MAX;
		else parts = pused_q;
	end

	ldg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	ldg_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.vertex        (vertex),
		.neighbor      (neighbor),
		.has_neighbor  (has_neighbor),
		.last          (last),
		.limit         (limit_q),
		.parts         (parts),
		.done          (done),
		.placed_vertex (placed_vertex),
		.partition     (partition)
	);

endmodule
